>>> src/gdda_pkg.sv
// shared types and constants of the grid ray caster
package gdda_pkg;

	// fixed-point format of the fields
	localparam int FRAC_BITS = 16;
	localparam int CELL_W    = 6;
	localparam int POS_W     = 22;
	localparam int DIR_W     = 18;
	localparam int PERP_W    = 24;
	localparam int DIST_W    = 56;

	// reciprocal 2^(2*FRAC_BITS) / |dir| needs one bit more than the shift
	localparam int QUOT_W = 2 * FRAC_BITS + 1;
	localparam int MAG_W  = DIR_W;
	localparam int FRC_W  = FRAC_BITS + 1;
	localparam int PROD_W = FRC_W + QUOT_W;

	localparam logic [FRAC_BITS:0]  FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DIST_W-1:0]   DIST_MAX = '1;
	localparam logic [PERP_W-1:0]   PERP_MAX = '1;

	// request kinds carried on s_tuser
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	// input tdata layout
	localparam int OFS_CELL_X = 0;
	localparam int OFS_CELL_Y = OFS_CELL_X + CELL_W;
	localparam int OFS_WALL   = OFS_CELL_Y + CELL_W;
	localparam int OFS_POS_X  = OFS_WALL + 1;
	localparam int OFS_POS_Y  = OFS_POS_X + POS_W;
	localparam int OFS_DIR_X  = OFS_POS_Y + POS_W;
	localparam int OFS_DIR_Y  = OFS_DIR_X + DIR_W;
	localparam int S_FIELDS_W = OFS_DIR_Y + DIR_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

	// output tdata layout
	localparam int OFS_PERP   = 0;
	localparam int OFS_HIT_X  = OFS_PERP + PERP_W;
	localparam int OFS_HIT_Y  = OFS_HIT_X + CELL_W;
	localparam int OFS_SIDE   = OFS_HIT_Y + CELL_W;
	localparam int M_FIELDS_W = OFS_SIDE + 1;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// cast sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_MULX,
		ST_MULY,
		ST_STEP,
		ST_TEST,
		ST_OUT
	} cast_state_t;

endpackage

>>> src/gdda_recip.sv
// bit-serial restoring divider for the reciprocal 2^(2*FRAC_BITS) / divisor
module gdda_recip (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gdda_pkg::MAG_W-1:0]   divisor,
	output logic                         done,
	output logic [gdda_pkg::QUOT_W-1:0]  quot
);
	import gdda_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] div_q;
	logic [MAG_W-1:0] rem_q;
	logic [QUOT_W-1:0] quot_q;

	logic             num_bit;
	logic [MAG_W:0]   rem_sh;
	logic [MAG_W:0]   rem_diff;
	logic             ge;
	logic [MAG_W-1:0] rem_nx;

	// dividend is a single one in its top bit
	assign num_bit  = (cnt_q == CNT_W'(QUOT_W - 1));
	assign rem_sh   = {rem_q, num_bit};
	assign ge       = (rem_sh >= {1'b0, div_q});
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign rem_nx   = ge ? rem_diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> src/gdda_map.sv
// wall-bit map store, one row per word, with a clearing pass after reset
module gdda_map #(
	parameter int MAP_W = 64,
	parameter int MAP_H = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [$clog2(MAP_H)-1:0]   wr_row,
	input  logic [$clog2(MAP_W)-1:0]   wr_col,
	input  logic                       wr_bit,
	input  logic [$clog2(MAP_H)-1:0]   rd_row,
	output logic [MAP_W-1:0]           rd_data,
	output logic                       busy
);
	import gdda_pkg::*;

	localparam int ROW_W = $clog2(MAP_H);

	logic [MAP_W-1:0] map_mem_q [MAP_H];
	logic [MAP_W-1:0] rd_data_q;
	logic [ROW_W-1:0] clr_row_q;
	logic             clr_busy_q;

	// clearing pass, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_row_q == ROW_W'(MAP_H - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + ROW_W'(1);
		end
	end

	// single write port, registered row read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			map_mem_q[clr_row_q] <= '0;
		end else if (wr_en) begin
			map_mem_q[wr_row][wr_col] <= wr_bit;
		end
		rd_data_q <= map_mem_q[rd_row];
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

>>> src/grid_ray_dda_caster.sv
// grid ray caster: map store, reciprocal unit and cell-stepping sequencer
//
//  channel | direction | tdata                                        | tuser
//  s_*     | in        | cell_x cell_y cell_wall pos_x pos_y dirx diry | req_type
//  m_*     | out       | perp_dist hit_x hit_y face                   | no_hit
//
// a cast computes the two reciprocals one after the other in the bit-serial divider,
// then walks the grid: every grid step takes two states, ST_STEP to step and read
// the map row, ST_TEST to test the cell. after reset the map is cleared one row a
// cycle, with s_tready low. a finished result waits in the output register; the next
// transaction is taken meanwhile, and a cast finishing behind it waits for m_tready.
module grid_ray_dda_caster #(
	parameter int MAP_W     = 64,
	parameter int MAP_H     = 64,
	parameter int MAX_STEPS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// cell_x, cell_y, cell_wall, pos_x, pos_y, dir_x, dir_y, zero fill
	input  logic [gdda_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// perp_dist, hit_x, hit_y, hit_face, zero fill
	output logic [gdda_pkg::M_TDATA_W-1:0]  m_tdata,
	// no_hit
	output logic                            m_tuser
);
	import gdda_pkg::*;

	localparam int COL_W = $clog2(MAP_W);
	localparam int ROW_W = $clog2(MAP_H);
	localparam int DIM_MAX = (MAP_W > MAP_H) ? MAP_W : MAP_H;
	localparam int CRD_W = $clog2(DIM_MAX + 65) + 1;
	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	cast_state_t state_q, state_nx;

	// input fields
	logic [CELL_W-1:0] in_cell_x, in_cell_y;
	logic              in_wall;
	logic [POS_W-1:0]  in_pos_x, in_pos_y;
	logic [DIR_W-1:0]  in_dir_x, in_dir_y;

	// cast working registers
	logic signed [CRD_W-1:0] cx_q, cy_q;
	logic                    neg_x_q, neg_y_q;
	logic                    zero_x_q, zero_y_q;
	logic [MAG_W-1:0]        mag_x_q, mag_y_q;
	logic [FRC_W-1:0]        f_x_q, f_y_q;
	logic [DIST_W-1:0]       dx_q, dy_q;
	logic [DIST_W-1:0]       side_x_q, side_y_q;
	logic                    side_q;
	logic                    oob_q;
	logic                    nohit_q;
	logic [CNT_W-1:0]        step_cnt_q;

	// output register
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic                    m_tuser_q;

	// control
	logic s_accept, cast_accept, write_accept;
	logic div_start, div_done;
	logic [MAG_W-1:0]  div_divisor;
	logic [QUOT_W-1:0] div_quot;
	logic out_free, out_load;
	logic map_busy;
	logic wall;

	// map interface
	logic [CRD_W-1:0]   wcx, wcy;
	logic               wr_en;
	logic [MAP_W-1:0]   rd_data;

	// accept-time arithmetic
	logic [MAG_W-1:0] in_mag_x, in_mag_y;
	logic [FRC_W-1:0] in_f_x, in_f_y;

	// shared multiplier
	logic [FRC_W-1:0]  mul_a;
	logic [QUOT_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [DIST_W-1:0] side_init;

	// stepping
	logic                    step_x;
	logic [DIST_W-1:0]       add_a, add_b;
	logic [DIST_W:0]         add_sum;
	logic [DIST_W-1:0]       add_sat;
	logic signed [CRD_W-1:0] cx_n, cy_n;
	logic                    oob_n;

	// result
	logic [DIST_W-1:0]       hit_s, hit_d, perp_diff, perp_full;
	logic [PERP_W-1:0]       perp;
	logic signed [CRD_W-1:0] hx_c, hy_c;
	logic [M_TDATA_W-1:0]    res_tdata;

	// unpack the input transaction
	assign in_cell_x = s_tdata[OFS_CELL_X +: CELL_W];
	assign in_cell_y = s_tdata[OFS_CELL_Y +: CELL_W];
	assign in_wall   = s_tdata[OFS_WALL];
	assign in_pos_x  = s_tdata[OFS_POS_X +: POS_W];
	assign in_pos_y  = s_tdata[OFS_POS_Y +: POS_W];
	assign in_dir_x  = s_tdata[OFS_DIR_X +: DIR_W];
	assign in_dir_y  = s_tdata[OFS_DIR_Y +: DIR_W];

	assign s_accept     = s_tvalid && s_tready;
	assign cast_accept  = s_accept && (s_tuser == REQ_CAST);
	assign write_accept = s_accept && (s_tuser == REQ_WRITE);

	// direction magnitudes and the first-boundary fractions
	assign in_mag_x = in_dir_x[DIR_W-1] ? (~in_dir_x + MAG_W'(1)) : in_dir_x;
	assign in_mag_y = in_dir_y[DIR_W-1] ? (~in_dir_y + MAG_W'(1)) : in_dir_y;
	assign in_f_x = in_dir_x[DIR_W-1] ? {1'b0, in_pos_x[FRAC_BITS-1:0]}
	                                  : FRAC_ONE - {1'b0, in_pos_x[FRAC_BITS-1:0]};
	assign in_f_y = in_dir_y[DIR_W-1] ? {1'b0, in_pos_y[FRAC_BITS-1:0]}
	                                  : FRAC_ONE - {1'b0, in_pos_y[FRAC_BITS-1:0]};

	// map writes outside the map are dropped
	assign wcx   = {{(CRD_W-CELL_W){1'b0}}, in_cell_x};
	assign wcy   = {{(CRD_W-CELL_W){1'b0}}, in_cell_y};
	assign wr_en = write_accept && (wcx < CRD_W'(MAP_W)) && (wcy < CRD_W'(MAP_H));

	gdda_map #(
		.MAP_W (MAP_W),
		.MAP_H (MAP_H)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_row  (wcy[ROW_W-1:0]),
		.wr_col  (wcx[COL_W-1:0]),
		.wr_bit  (in_wall),
		.rd_row  (cy_n[ROW_W-1:0]),
		.rd_data (rd_data),
		.busy    (map_busy)
	);

	gdda_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (div_quot)
	);

	// shared multiplier for the two first side distances
	assign mul_a     = (state_q == ST_MULX) ? f_x_q : f_y_q;
	assign mul_b     = (state_q == ST_MULX) ? dx_q[QUOT_W-1:0] : dy_q[QUOT_W-1:0];
	assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign side_init = DIST_W'(prod[PROD_W-1:FRAC_BITS]);

	// one step: smaller side distance advances, ties go to y
	assign step_x  = (side_x_q < side_y_q);
	assign add_a   = step_x ? side_x_q : side_y_q;
	assign add_b   = step_x ? dx_q : dy_q;
	assign add_sum = {1'b0, add_a} + {1'b0, add_b};
	assign add_sat = add_sum[DIST_W] ? DIST_MAX : add_sum[DIST_W-1:0];

	always_comb begin
		cx_n = cx_q;
		cy_n = cy_q;
		if (step_x) begin
			cx_n = neg_x_q ? (cx_q - CRD_W'(1)) : (cx_q + CRD_W'(1));
		end else begin
			cy_n = neg_y_q ? (cy_q - CRD_W'(1)) : (cy_q + CRD_W'(1));
		end
	end

	assign oob_n = (cx_n < 0) || (cx_n >= MAP_W) || (cy_n < 0) || (cy_n >= MAP_H);

	// cells outside the map are walls
	assign wall = oob_q || rd_data[cx_q[COL_W-1:0]];

	// perpendicular distance on the hit axis, floored and saturated
	assign hit_s     = side_q ? side_y_q : side_x_q;
	assign hit_d     = side_q ? dy_q : dx_q;
	assign perp_diff = hit_s - hit_d;
	assign perp_full = (hit_s >= hit_d) ? perp_diff : '0;
	assign perp      = (|perp_full[DIST_W-1:PERP_W]) ? PERP_MAX : perp_full[PERP_W-1:0];

	// hit cell clamped into the map
	assign hx_c = (cx_q < 0) ? '0 : (cx_q >= MAP_W) ? CRD_W'(MAP_W - 1) : cx_q;
	assign hy_c = (cy_q < 0) ? '0 : (cy_q >= MAP_H) ? CRD_W'(MAP_H - 1) : cy_q;

	assign res_tdata = nohit_q ? {{M_PAD_W{1'b0}}, 1'b0, {CELL_W{1'b0}}, {CELL_W{1'b0}},
	                              PERP_MAX}
	                           : {{M_PAD_W{1'b0}}, side_q, hy_c[CELL_W-1:0],
	                              hx_c[CELL_W-1:0], perp};

	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cast_accept) begin
					state_nx = ST_DIVX_GO;
				end
			end
			ST_DIVX_GO: begin
				state_nx = ST_DIVX_WAIT;
			end
			ST_DIVX_WAIT: begin
				if (div_done) begin
					state_nx = ST_DIVY_GO;
				end
			end
			ST_DIVY_GO: begin
				state_nx = ST_DIVY_WAIT;
			end
			ST_DIVY_WAIT: begin
				if (div_done) begin
					state_nx = ST_MULX;
				end
			end
			ST_MULX: begin
				state_nx = ST_MULY;
			end
			ST_MULY: begin
				state_nx = ST_STEP;
			end
			ST_STEP: begin
				state_nx = ST_TEST;
			end
			ST_TEST: begin
				priority if (wall) begin
					state_nx = ST_OUT;
				end else if (step_cnt_q == CNT_W'(MAX_STEPS)) begin
					state_nx = ST_OUT;
				end else begin
					state_nx = ST_STEP;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready    = 1'b0;
		div_start   = 1'b0;
		div_divisor = mag_y_q;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !map_busy;
			end
			ST_DIVX_GO: begin
				div_start   = 1'b1;
				div_divisor = mag_x_q;
			end
			ST_DIVY_GO: begin
				div_start = 1'b1;
			end
			ST_OUT: begin
				out_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// state register and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cast_accept) begin
				step_cnt_q <= '0;
			end else if (state_q == ST_STEP) begin
				step_cnt_q <= step_cnt_q + CNT_W'(1);
			end
		end
	end

	// cast datapath
	always_ff @(posedge clk) begin
		if (cast_accept) begin
			cx_q     <= {{(CRD_W-CELL_W){1'b0}}, in_pos_x[POS_W-1:FRAC_BITS]};
			cy_q     <= {{(CRD_W-CELL_W){1'b0}}, in_pos_y[POS_W-1:FRAC_BITS]};
			neg_x_q  <= in_dir_x[DIR_W-1];
			neg_y_q  <= in_dir_y[DIR_W-1];
			zero_x_q <= (in_dir_x == '0);
			zero_y_q <= (in_dir_y == '0);
			mag_x_q  <= in_mag_x;
			mag_y_q  <= in_mag_y;
			f_x_q    <= in_f_x;
			f_y_q    <= in_f_y;
		end
		if (state_q == ST_DIVX_WAIT && div_done) begin
			dx_q <= zero_x_q ? DIST_MAX : DIST_W'(div_quot);
		end
		if (state_q == ST_DIVY_WAIT && div_done) begin
			dy_q <= zero_y_q ? DIST_MAX : DIST_W'(div_quot);
		end
		if (state_q == ST_MULX) begin
			side_x_q <= zero_x_q ? DIST_MAX : side_init;
		end
		if (state_q == ST_MULY) begin
			side_y_q <= zero_y_q ? DIST_MAX : side_init;
		end
		if (state_q == ST_STEP) begin
			if (step_x) begin
				side_x_q <= add_sat;
			end else begin
				side_y_q <= add_sat;
			end
			cx_q   <= cx_n;
			cy_q   <= cy_n;
			side_q <= !step_x;
			oob_q  <= oob_n;
		end
		if (state_q == ST_TEST) begin
			nohit_q <= !wall;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_tdata;
			m_tuser_q <= nohit_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// no transaction is taken while the map is being cleared
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !s_tready)
		else $error("input taken during map clearing pass");

	// the walk never goes past the step limit
	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		step_cnt_q <= CNT_W'(MAX_STEPS))
		else $error("step count beyond limit");

	// a reciprocal finishes only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVX_WAIT || state_q == ST_DIVY_WAIT))
		else $error("reciprocal finished outside its wait state");

	// a miss carries the saturated distance and a zero cell
	a_nohit_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[OFS_PERP +: PERP_W] == PERP_MAX
			&& m_tdata[OFS_HIT_X +: 2*CELL_W+1] == '0))
		else $error("miss result with hit fields set");

endmodule
